// File: hw/rtl/keypoint_occupancy_histogram_assert.svh
// Assertion macros shared by the keypoint occupancy histogram RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the including module.
`ifndef KEYPOINT_OCCUPANCY_HISTOGRAM_ASSERT_SVH
`define KEYPOINT_OCCUPANCY_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define KOH_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define KOH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/koh_pkg.sv
// Shared types, constants and the divider step for the keypoint occupancy histogram.
// No dependencies; imported by koh_ram users and the top level.
package koh_pkg;

	localparam int MAX_BINS_X    = 64;
	localparam int MAX_BINS_Y    = 64;
	localparam int MAX_KEYPOINTS = 64;
	localparam int COORD_BITS    = 12;

	localparam int SUM_W      = COORD_BITS + 6;
	localparam int CNT_W      = 7;
	localparam int CFG_BINS_W = 7;
	localparam int FRAME_W    = 12;
	localparam int BIN_W      = 16;
	localparam int COL_W      = 6;
	localparam int BIN_DEPTH  = MAX_BINS_X * MAX_BINS_Y;
	localparam int BIN_ADDR_W = $clog2(BIN_DEPTH);
	localparam int DIV_STEPS  = SUM_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int REM_W      = FRAME_W;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CONF_CUTOFF  = 3'd0;
	localparam cfg_idx_t CFG_BINS_ACROSS  = 3'd1;
	localparam cfg_idx_t CFG_BINS_DOWN    = 3'd2;
	localparam cfg_idx_t CFG_FRAME_WIDTH  = 3'd3;
	localparam cfg_idx_t CFG_FRAME_HEIGHT = 3'd4;
	localparam cfg_idx_t CFG_KP_SELECT    = 3'd5;
	localparam cfg_idx_t CFG_HIST_ENABLE  = 3'd6;

	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [15:0] confidence;
		logic [5:0]  keypoint_index;
		logic        last_keypoint;
	} kp_t;

	typedef struct packed {
		logic        hit;
		logic [5:0]  bin_col;
		logic [5:0]  bin_row;
		logic [15:0] bin_count;
		logic [15:0] max_count;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV_AVG,
		ST_SCALE,
		ST_DIV_BIN,
		ST_READ,
		ST_UPDATE
	} state_t;

	// One lane of the restoring divider: partial remainder and dividend/quotient shifter
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [SUM_W-1:0] dvd;
	} div_lane_t;

	// Retire one quotient bit: shift in the next dividend bit, subtract if it fits
	function automatic div_lane_t div_step(div_lane_t l, logic [REM_W-1:0] dvs);
		logic [REM_W:0] trial;
		logic           ge;
		div_lane_t      r;
		trial = {l.rem, l.dvd[SUM_W-1]};
		ge    = (trial >= {1'b0, dvs});
		r.rem = ge ? REM_W'(trial - {1'b0, dvs}) : trial[REM_W-1:0];
		r.dvd = {l.dvd[SUM_W-2:0], ge};
		return r;
	endfunction

endpackage

// File: hw/rtl/koh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module koh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/keypoint_occupancy_histogram.sv
// Keypoint occupancy histogram top level: accumulation, bit-serial dividers, bin store.
// Depends on koh_pkg, koh_ram and keypoint_occupancy_histogram_assert.svh.
//
// Keypoints stream in one per transfer; a keypoint that is not the last of its frame is
// taken whenever the block is idle, so such keypoints may follow back to back. The last
// keypoint of a frame that yields a hit occupies the block while two 18-step restoring
// dividers (one bit per cycle, x and y side by side) form the averages, a scale state
// multiplies them by the bin counts, the same dividers run 18 more steps against the
// frame size, then a read and a write of the bin store finish the update. A last keypoint
// without a hit has its result registered as it is taken. After reset the 4096-entry bin
// store is cleared one entry per cycle, so no keypoint is taken until the clear is done;
// configuration writes are taken at any time.
`include "keypoint_occupancy_histogram_assert.svh"

module keypoint_occupancy_histogram
	import koh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  kp_valid,
	output logic                  kp_ready,
	input  kp_t                   kp,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res
);

	// Configuration registers
	logic [15:0]            cutoff_q;
	logic [CFG_BINS_W-1:0]  bins_across_q;
	logic [CFG_BINS_W-1:0]  bins_down_q;
	logic [FRAME_W-1:0]     frame_width_q;
	logic [FRAME_W-1:0]     frame_height_q;
	logic [MAX_KEYPOINTS-1:0] select_q;
	logic                   hist_en_q;

	// Control and per-frame state
	state_t                 state_q, state_nx;
	logic [BIN_ADDR_W-1:0]  clr_addr_q;
	logic [SUM_W-1:0]       sum_x_q, sum_y_q;
	logic [CNT_W-1:0]       qcnt_q;
	logic [STEP_W-1:0]      step_q;
	logic [BIN_W-1:0]       peak_q;
	logic                   res_valid_q;

	// Datapath registers
	div_lane_t              lane_x_q, lane_y_q;
	logic [REM_W-1:0]       dvs_x_q, dvs_y_q;
	logic [CFG_BINS_W-1:0]  bx_q, by_q;
	logic [COL_W-1:0]       col_q, row_q;
	res_t                   res_q;

	// Combinational signals
	logic                   kp_acc;
	logic                   qual;
	logic [SUM_W:0]         sx_add, sy_add;
	logic [SUM_W-1:0]       sx_nx, sy_nx;
	logic [CNT_W-1:0]       qcnt_nx;
	logic                   start_div;
	logic                   step_last;
	logic [CFG_BINS_W-1:0]  eff_bx, eff_by;
	logic [FRAME_W-1:0]     eff_fw, eff_fh;
	logic [COL_W-1:0]       col_nx, row_nx;
	logic [BIN_W-1:0]       bin_inc;
	logic [BIN_W-1:0]       peak_nx;
	logic                   commit;
	logic                   ram_we;
	logic [BIN_ADDR_W-1:0]  ram_waddr;
	logic [BIN_W-1:0]       ram_wdata;
	logic                   ram_re;
	logic [BIN_ADDR_W-1:0]  ram_raddr;
	logic [BIN_W-1:0]       ram_rdata;
	div_lane_t              step_x, step_y;

	function automatic logic [BIN_ADDR_W-1:0] bin_addr(logic [COL_W-1:0] row,
		logic [COL_W-1:0] col);
		return BIN_ADDR_W'(row) * BIN_ADDR_W'(MAX_BINS_X) + BIN_ADDR_W'(col);
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q       <= '0;
			bins_across_q  <= CFG_BINS_W'(20);
			bins_down_q    <= CFG_BINS_W'(20);
			frame_width_q  <= FRAME_W'(640);
			frame_height_q <= FRAME_W'(480);
			select_q       <= '0;
			hist_en_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONF_CUTOFF:  cutoff_q       <= cfg_data[15:0];
				CFG_BINS_ACROSS:  bins_across_q  <= cfg_data[CFG_BINS_W-1:0];
				CFG_BINS_DOWN:    bins_down_q    <= cfg_data[CFG_BINS_W-1:0];
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_W-1:0];
				CFG_KP_SELECT:    select_q       <= cfg_data[MAX_KEYPOINTS-1:0];
				CFG_HIST_ENABLE:  hist_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Qualify the keypoint and form the saturating sums and count
	always_comb begin
		qual = ({1'b0, kp.keypoint_index} < 7'(MAX_KEYPOINTS))
			&& select_q[kp.keypoint_index[$clog2(MAX_KEYPOINTS)-1:0]]
			&& (kp.confidence > cutoff_q);
		sx_add  = {1'b0, sum_x_q} + (SUM_W+1)'(kp.pos_x);
		sy_add  = {1'b0, sum_y_q} + (SUM_W+1)'(kp.pos_y);
		sx_nx   = sum_x_q;
		sy_nx   = sum_y_q;
		qcnt_nx = qcnt_q;
		if (qual) begin
			sx_nx   = sx_add[SUM_W] ? '1 : sx_add[SUM_W-1:0];
			sy_nx   = sy_add[SUM_W] ? '1 : sy_add[SUM_W-1:0];
			qcnt_nx = (qcnt_q == '1) ? qcnt_q : qcnt_q + CNT_W'(1);
		end
	end

	// Effective grid and frame sizes
	always_comb begin
		eff_bx = (bins_across_q == '0) ? CFG_BINS_W'(1) :
			(bins_across_q > CFG_BINS_W'(MAX_BINS_X)) ? CFG_BINS_W'(MAX_BINS_X) : bins_across_q;
		eff_by = (bins_down_q == '0) ? CFG_BINS_W'(1) :
			(bins_down_q > CFG_BINS_W'(MAX_BINS_Y)) ? CFG_BINS_W'(MAX_BINS_Y) : bins_down_q;
		eff_fw = (frame_width_q == '0) ? FRAME_W'(1) : frame_width_q;
		eff_fh = (frame_height_q == '0) ? FRAME_W'(1) : frame_height_q;
	end

	// Divider steps, bin clamp and saturating bin increment
	always_comb begin
		step_x    = div_step(lane_x_q, dvs_x_q);
		step_y    = div_step(lane_y_q, dvs_y_q);
		step_last = (step_q == STEP_W'(DIV_STEPS - 1));
		col_nx    = (lane_x_q.dvd >= SUM_W'(bx_q)) ? COL_W'(bx_q - CFG_BINS_W'(1))
			: lane_x_q.dvd[COL_W-1:0];
		row_nx    = (lane_y_q.dvd >= SUM_W'(by_q)) ? COL_W'(by_q - CFG_BINS_W'(1))
			: lane_y_q.dvd[COL_W-1:0];
		bin_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + BIN_W'(1);
		peak_nx   = (bin_inc > peak_q) ? bin_inc : peak_q;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_addr_q == BIN_ADDR_W'(BIN_DEPTH - 1)) state_nx = ST_IDLE;
			ST_IDLE:    if (start_div) state_nx = ST_DIV_AVG;
			ST_DIV_AVG: if (step_last) state_nx = ST_SCALE;
			ST_SCALE:   state_nx = ST_DIV_BIN;
			ST_DIV_BIN: if (step_last) state_nx = ST_READ;
			ST_READ:    state_nx = ST_UPDATE;
			ST_UPDATE:  if (!res_valid_q) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// State machine outputs
	always_comb begin
		kp_ready  = 1'b0;
		commit    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = bin_addr(row_q, col_q);
		ram_wdata = bin_inc;
		ram_re    = 1'b0;
		ram_raddr = bin_addr(row_nx, col_nx);
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				kp_ready = !kp.last_keypoint || !res_valid_q;
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_UPDATE: begin
				commit = !res_valid_q;
				ram_we = !res_valid_q;
			end
			default: ;
		endcase
	end

	assign kp_acc    = kp_valid && kp_ready;
	assign start_div = kp_acc && kp.last_keypoint && hist_en_q && (qcnt_nx != '0);

	// Control registers: clearing sweep, sums, step counter, peak, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			qcnt_q      <= '0;
			step_q      <= '0;
			peak_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + BIN_ADDR_W'(1);
			end
			// Accumulate, or drop the frame's sums on its last keypoint
			if (kp_acc) begin
				if (kp.last_keypoint) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					qcnt_q  <= '0;
				end else begin
					sum_x_q <= sx_nx;
					sum_y_q <= sy_nx;
					qcnt_q  <= qcnt_nx;
				end
			end
			// Advance the divider step count; restart it at each division
			if (state_q == ST_DIV_AVG || state_q == ST_DIV_BIN) begin
				step_q <= step_last ? '0 : step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (commit) begin
				peak_q <= peak_nx;
			end
			// Hold the result until its transfer
			if (commit || (kp_acc && kp.last_keypoint && !start_div)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Divider lanes, scaling and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start_div) begin
					lane_x_q <= '{rem: '0, dvd: sx_nx};
					lane_y_q <= '{rem: '0, dvd: sy_nx};
					dvs_x_q  <= REM_W'(qcnt_nx);
					dvs_y_q  <= REM_W'(qcnt_nx);
				end
			end
			ST_DIV_AVG, ST_DIV_BIN: begin
				lane_x_q <= step_x;
				lane_y_q <= step_y;
			end
			ST_SCALE: begin
				// Averages fit COORD_BITS even when the sums saturate
				lane_x_q <= '{rem: '0,
					dvd: SUM_W'(lane_x_q.dvd[COORD_BITS-1:0]) * SUM_W'(eff_bx)};
				lane_y_q <= '{rem: '0,
					dvd: SUM_W'(lane_y_q.dvd[COORD_BITS-1:0]) * SUM_W'(eff_by)};
				dvs_x_q  <= eff_fw;
				dvs_y_q  <= eff_fh;
				bx_q     <= eff_bx;
				by_q     <= eff_by;
			end
			ST_READ: begin
				col_q <= col_nx;
				row_q <= row_nx;
			end
			default: ;
		endcase
		if (commit) begin
			res_q <= '{hit: 1'b1, bin_col: col_q, bin_row: row_q,
				bin_count: bin_inc, max_count: peak_nx};
		end else if (kp_acc && kp.last_keypoint && !start_div) begin
			res_q <= '{hit: 1'b0, bin_col: '0, bin_row: '0, bin_count: '0,
				max_count: peak_q};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Bin count store
	koh_ram #(
		.WIDTH(BIN_W),
		.DEPTH(BIN_DEPTH)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`KOH_ASSERT_IMPL(a_no_take_in_clear, state_q == ST_CLEAR, !kp_ready, "keypoint taken during clear")
	`KOH_ASSERT_IMPL(a_miss_zero, res_valid && !res.hit, res.bin_count == '0 && res.bin_col == '0 && res.bin_row == '0, "miss result carries bin data")
	`KOH_ASSERT_IMPL(a_hit_count, res_valid && res.hit, res.bin_count != '0 && res.max_count >= res.bin_count, "hit count inconsistent with peak")
	`KOH_ASSERT_NEXT(a_peak_mono, 1'b1, peak_q >= $past(peak_q), "peak count decreased")
	`KOH_ASSERT_IMPL(a_step_range, state_q == ST_DIV_AVG || state_q == ST_DIV_BIN, step_q < STEP_W'(DIV_STEPS), "divider step out of range")

endmodule

// File: verif/tb.sv
// Testbench for keypoint_occupancy_histogram: directed table, then randomized frames.
// Checks each result against a built-in bin-update predictor or a pinned expectation; depends on koh_pkg and the DUT.
module tb;
	import koh_pkg::*;

	localparam int unsigned SUM_CAP = (1 << SUM_W) - 1;
	localparam int unsigned CNT_CAP = (1 << CNT_W) - 1;
	localparam int unsigned BIN_CAP = (1 << BIN_W) - 1;
	localparam int SETTLE_CYCLES = 48;
	localparam int PHASE_ITEMS = 225;

	typedef enum bit {ROW_REG, ROW_KP} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cfg_idx_t reg_idx;
		logic [63:0] reg_val;
		kp_t item;
		bit pinned;
		res_t want;
	} drow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_CONF_CUTOFF;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic kp_valid = 1'b0;
	logic kp_ready;
	kp_t kp = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	// Shadow copy of the configuration
	logic [15:0] cut_lvl = 16'd0;
	logic [6:0] across_reg = 7'd20;
	logic [6:0] down_reg = 7'd20;
	logic [11:0] fwidth_reg = 12'd640;
	logic [11:0] fheight_reg = 12'd480;
	logic [63:0] select_mask = '0;
	logic hist_on = 1'b0;

	// Predictor state
	int unsigned acc_x = 0;
	int unsigned acc_y = 0;
	int unsigned acc_n = 0;
	logic [15:0] grid_counts [BIN_DEPTH];
	int unsigned grid_peak = 0;

	res_t bin_results_due[$];
	drow_t directed_rows[$];
	int mismatch_count = 0;
	bit steady = 1'b0;

	keypoint_occupancy_histogram dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.kp_valid(kp_valid),
		.kp_ready(kp_ready),
		.kp(kp),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always #10 clk = ~clk;

	// Accumulate one keypoint; on the last one, work out the bin update
	task automatic predict_bin_update(input kp_t k, output bit emits, output res_t r);
		int unsigned bx, by, fw, fh, ax, ay, col, row, slot, cnt;
		r = '0;
		emits = 1'b0;
		if (select_mask[k.keypoint_index] && k.confidence > cut_lvl) begin
			acc_x = (acc_x + k.pos_x > SUM_CAP) ? SUM_CAP : acc_x + k.pos_x;
			acc_y = (acc_y + k.pos_y > SUM_CAP) ? SUM_CAP : acc_y + k.pos_y;
			acc_n = (acc_n + 1 > CNT_CAP) ? CNT_CAP : acc_n + 1;
		end
		if (!k.last_keypoint)
			return;
		emits = 1'b1;
		if (hist_on && acc_n != 0) begin
			bx = (across_reg == 0) ? 1 : (across_reg > MAX_BINS_X ? MAX_BINS_X : across_reg);
			by = (down_reg == 0) ? 1 : (down_reg > MAX_BINS_Y ? MAX_BINS_Y : down_reg);
			fw = (fwidth_reg == 0) ? 1 : fwidth_reg;
			fh = (fheight_reg == 0) ? 1 : fheight_reg;
			ax = acc_x / acc_n;
			ay = acc_y / acc_n;
			col = (ax * bx) / fw;
			row = (ay * by) / fh;
			if (col > bx - 1)
				col = bx - 1;
			if (row > by - 1)
				row = by - 1;
			slot = row * MAX_BINS_X + col;
			cnt = (grid_counts[slot] + 1 > BIN_CAP) ? BIN_CAP : grid_counts[slot] + 1;
			grid_counts[slot] = 16'(cnt);
			if (cnt > grid_peak)
				grid_peak = cnt;
			r.hit = 1'b1;
			r.bin_col = 6'(col);
			r.bin_row = 6'(row);
			r.bin_count = 16'(cnt);
		end
		r.max_count = 16'(grid_peak);
		acc_x = 0;
		acc_y = 0;
		acc_n = 0;
	endtask

	// Drop valid and hold until every expected result is back, then let the block settle
	task automatic settle();
		kp_valid <= 1'b0;
		while (bin_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle
	task automatic load_reg(input cfg_idx_t idx, input logic [63:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CONF_CUTOFF: cut_lvl = val[15:0];
			CFG_BINS_ACROSS: across_reg = val[6:0];
			CFG_BINS_DOWN: down_reg = val[6:0];
			CFG_FRAME_WIDTH: fwidth_reg = val[11:0];
			CFG_FRAME_HEIGHT: fheight_reg = val[11:0];
			CFG_KP_SELECT: select_mask = val;
			CFG_HIST_ENABLE: hist_on = val[0];
			default: ;
		endcase
	endtask

	// Offer one keypoint, hold it until the transfer, then record what it should cause
	task automatic send_kp(input kp_t item, input bit pinned, input res_t pinned_res);
		bit emits;
		res_t r;
		while (!steady && $urandom_range(99) < 22) begin
			kp_valid <= 1'b0;
			@(posedge clk);
		end
		kp_valid <= 1'b1;
		kp <= item;
		@(posedge clk);
		while (!kp_ready)
			@(posedge clk);
		predict_bin_update(item, emits, r);
		if (emits)
			bin_results_due.push_back(pinned ? pinned_res : r);
	endtask

	function automatic kp_t make_kp(int x, int y, int c, int i, int l);
		kp_t k;
		k.pos_x = 12'(x);
		k.pos_y = 12'(y);
		k.confidence = 16'(c);
		k.keypoint_index = 6'(i);
		k.last_keypoint = 1'(l);
		return k;
	endfunction

	function automatic void add_reg(cfg_idx_t idx, logic [63:0] val);
		drow_t d;
		d = '{ROW_REG, idx, val, '0, 1'b0, '0};
		directed_rows.push_back(d);
	endfunction

	function automatic void add_kp(int x, int y, int c, int i, int l, bit pinned, res_t want);
		drow_t d;
		d = '{ROW_KP, CFG_CONF_CUTOFF, '0, make_kp(x, y, c, i, l), pinned, want};
		directed_rows.push_back(d);
	endfunction

	function automatic logic [6:0] rand_bins();
		return 7'(($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64));
	endfunction

	function automatic logic [11:0] rand_size();
		return 12'(($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4095));
	endfunction

	// One frame of keypoints; heavy frames push the sums and the count into saturation
	task automatic run_frame(input int len, input bit heavy);
		kp_t k;
		for (int n = 0; n < len; n++) begin
			if (heavy) begin
				k = make_kp($urandom_range(3000, 4095), $urandom_range(3000, 4095), 16'hFFFF,
					$urandom_range(0, 63), n == len - 1);
			end else begin
				k = make_kp(($urandom_range(3) == 0) ? $urandom_range(0, 4095)
						: $urandom_range(0, fwidth_reg),
					($urandom_range(3) == 0) ? $urandom_range(0, 4095)
						: $urandom_range(0, fheight_reg),
					($urandom_range(1) == 0 || cut_lvl == 16'hFFFF) ? $urandom_range(0, 65535)
						: $urandom_range(cut_lvl + 1, 65535),
					$urandom_range(0, 63), n == len - 1);
			end
			send_kp(k, 1'b0, '0);
		end
	endtask

	// Drain results with random backpressure and check each against the oldest expectation
	always @(posedge clk) begin
		res_t w;
		if (arst_n && res_valid && res_ready) begin
			if (bin_results_due.size() == 0) begin
				$display("%0t: result with nothing expected: actual %p", $time, res);
				mismatch_count++;
			end else begin
				w = bin_results_due.pop_front();
				if (res.hit !== w.hit) begin
					$display("%0t: hit expected %0d actual %0d", $time, w.hit, res.hit);
					mismatch_count++;
				end
				if (res.bin_col !== w.bin_col) begin
					$display("%0t: bin_col expected %0d actual %0d", $time, w.bin_col,
						res.bin_col);
					mismatch_count++;
				end
				if (res.bin_row !== w.bin_row) begin
					$display("%0t: bin_row expected %0d actual %0d", $time, w.bin_row,
						res.bin_row);
					mismatch_count++;
				end
				if (res.bin_count !== w.bin_count) begin
					$display("%0t: bin_count expected %0d actual %0d", $time, w.bin_count,
						res.bin_count);
					mismatch_count++;
				end
				if (res.max_count !== w.max_count) begin
					$display("%0t: max_count expected %0d actual %0d", $time, w.max_count,
						res.max_count);
					mismatch_count++;
				end
			end
		end
		res_ready <= steady || ($urandom_range(99) >= 22);
	end

	initial begin
		int phase_items;
		foreach (grid_counts[i])
			grid_counts[i] = '0;

		// Reset config: nothing selected
		add_kp(100, 100, 16'hFFFF, 0, 1, 1'b1, res_t'{1'b0, 6'd0, 6'd0, 16'd0, 16'd0});
		add_reg(CFG_KP_SELECT, 64'hFFFF_FFFF_FFFF_FFFF);
		add_reg(CFG_HIST_ENABLE, 64'd1);
		// Confidence equal to the cutoff does not count
		add_kp(0, 0, 0, 0, 1, 1'b1, res_t'{1'b0, 6'd0, 6'd0, 16'd0, 16'd0});
		add_kp(0, 0, 1, 0, 1, 1'b1, res_t'{1'b1, 6'd0, 6'd0, 16'd1, 16'd1});
		// Corner of the frame lands past the grid and saturates
		add_kp(4095, 4095, 16'hFFFF, 63, 1, 1'b1, res_t'{1'b1, 6'd19, 6'd19, 16'd1, 16'd1});
		add_kp(0, 0, 1, 5, 1, 1'b1, res_t'{1'b1, 6'd0, 6'd0, 16'd2, 16'd2});
		add_reg(CFG_CONF_CUTOFF, 64'hFFFF);
		add_kp(10, 10, 16'hFFFF, 1, 1, 1'b1, res_t'{1'b0, 6'd0, 6'd0, 16'd0, 16'd2});
		add_reg(CFG_CONF_CUTOFF, 64'h8000);
		add_kp(100, 200, 16'h8000, 2, 0, 1'b0, '0);
		add_kp(100, 200, 16'h8001, 3, 0, 1'b0, '0);
		add_kp(300, 400, 16'h8001, 4, 1, 1'b0, '0);
		add_kp(640, 480, 16'hFFFF, 5, 1, 1'b0, '0);
		// Accumulate with the histogram off, then enable only before the last keypoint
		add_reg(CFG_HIST_ENABLE, 64'd0);
		add_kp(50, 50, 16'hFFFF, 6, 0, 1'b0, '0);
		add_kp(60, 60, 16'hFFFF, 7, 1, 1'b0, '0);
		add_kp(320, 240, 16'hFFFF, 8, 0, 1'b0, '0);
		add_reg(CFG_HIST_ENABLE, 64'd1);
		add_kp(0, 0, 0, 9, 1, 1'b0, '0);
		// Sparse select mask
		add_reg(CFG_KP_SELECT, 64'h8000_0000_0000_0001);
		add_kp(1000, 1000, 16'hFFFF, 1, 1, 1'b0, '0);
		add_kp(64, 48, 16'hFFFF, 63, 0, 1'b0, '0);
		add_kp(0, 0, 16'hFFFF, 0, 1, 1'b0, '0);
		// Zero bins, oversize bins, zero frame width
		add_reg(CFG_BINS_ACROSS, 64'd0);
		add_reg(CFG_BINS_DOWN, 64'd127);
		add_reg(CFG_FRAME_WIDTH, 64'd0);
		add_reg(CFG_FRAME_HEIGHT, 64'd4095);
		add_reg(CFG_KP_SELECT, 64'hFFFF_FFFF_FFFF_FFFF);
		add_kp(4095, 4095, 16'hFFFF, 10, 1, 1'b0, '0);
		add_kp(0, 0, 16'hFFFF, 11, 1, 1'b0, '0);
		add_reg(CFG_BINS_ACROSS, 64'd64);
		add_reg(CFG_BINS_DOWN, 64'd1);
		add_reg(CFG_FRAME_WIDTH, 64'd4095);
		add_reg(CFG_FRAME_HEIGHT, 64'd1);
		add_kp(4095, 0, 16'hFFFF, 12, 1, 1'b0, '0);
		add_kp(2047, 4095, 16'hFFFF, 13, 1, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_REG)
				load_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
			else
				send_kp(directed_rows[r].item, directed_rows[r].pinned, directed_rows[r].want);
		end

		// Random phases, each under its own configuration
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					load_reg(CFG_CONF_CUTOFF, 64'd0);
					load_reg(CFG_BINS_ACROSS, 64'd64);
					load_reg(CFG_BINS_DOWN, 64'd64);
					load_reg(CFG_FRAME_WIDTH, 64'd4095);
					load_reg(CFG_FRAME_HEIGHT, 64'd4095);
					load_reg(CFG_KP_SELECT, 64'hFFFF_FFFF_FFFF_FFFF);
					load_reg(CFG_HIST_ENABLE, 64'd1);
				end
				1: begin
					load_reg(CFG_CONF_CUTOFF, 64'hFFFE);
					load_reg(CFG_BINS_ACROSS, 64'd1);
					load_reg(CFG_BINS_DOWN, 64'd1);
					load_reg(CFG_FRAME_WIDTH, 64'd1);
					load_reg(CFG_FRAME_HEIGHT, 64'd1);
				end
				default: begin
					load_reg(CFG_CONF_CUTOFF, ($urandom_range(9) == 0) ? 64'hFFFF
						: $urandom_range(0, 40000));
					load_reg(CFG_BINS_ACROSS, rand_bins());
					load_reg(CFG_BINS_DOWN, rand_bins());
					load_reg(CFG_FRAME_WIDTH, rand_size());
					load_reg(CFG_FRAME_HEIGHT, rand_size());
					load_reg(CFG_KP_SELECT, {$urandom, $urandom} | {$urandom, $urandom});
					load_reg(CFG_HIST_ENABLE, ($urandom_range(3) != 0));
				end
			endcase
			steady = (ph == 3);
			phase_items = 0;
			if (ph == 0 || ph == 4) begin
				run_frame($urandom_range(180, 200), 1'b1);
				phase_items = phase_items + 190;
			end
			while (phase_items < PHASE_ITEMS) begin
				int len;
				len = ($urandom_range(79) == 0) ? $urandom_range(130, 150) : $urandom_range(1, 10);
				run_frame(len, len > 100);
				phase_items = phase_items + len;
				// Hold the sender once until the block has answered everything
				if (ph == 2 && phase_items >= PHASE_ITEMS / 2 && phase_items - len < PHASE_ITEMS / 2)
					settle();
			end
		end
		steady = 1'b0;

		settle();
		if (mismatch_count == 0 && bin_results_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/koh_pkg.sv
hw/rtl/koh_ram.sv
hw/rtl/keypoint_occupancy_histogram.sv
verif/tb.sv
